// ----- rtl/bresenham_line_pixel_generator_top_defines.svh -----
// Assertion macros shared by the line generator RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BRESENHAM_LINE_PIXEL_GENERATOR_TOP_DEFINES_SVH
`define BRESENHAM_LINE_PIXEL_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked only out of reset.
`define BLPG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line generator assertion failed");

// Next-cycle implication, checked only out of reset.
`define BLPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line generator assertion failed");

`endif

// ----- rtl/blpg_pkg.sv -----
`default_nettype none

package blpg_pkg;

    // Frame size registers and the framebuffer address.
    localparam int FRAME_BITS = 13;
    localparam int ADDR_BITS  = 24;

    localparam logic [FRAME_BITS-1:0] FRAME_RESET = 13'd700;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;

    // Operation codes carried by an input transaction.
    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] width;
        logic [FRAME_BITS-1:0] height;
    } frame_t;

endpackage

`default_nettype wire

// ----- rtl/blpg_step.sv -----
`default_nettype none

// Bresenham stepping core: holds line state; one pixel per start or live step.
module blpg_step #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         fire,
    input  wire logic                         operation,
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    output logic                              produce,
    output logic signed [COORD_BITS-1:0]      pix_x,
    output logic signed [COORD_BITS-1:0]      pix_y,
    output logic                              pix_last
);

    localparam int SPAN_BITS = COORD_BITS + 1;
    localparam int ERR_BITS  = COORD_BITS + 3;

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] goal_x_reg, goal_x_next;
    logic signed [COORD_BITS-1:0] goal_y_reg, goal_y_next;
    logic [SPAN_BITS-1:0]         span_x_reg, span_x_next;
    logic [SPAN_BITS-1:0]         span_y_reg, span_y_next;
    logic                         dir_x_reg, dir_x_next;
    logic                         dir_y_reg, dir_y_next;
    logic signed [ERR_BITS-1:0]   err_reg, err_next;
    logic                         active_reg, active_next;

    logic                         is_start;
    logic signed [COORD_BITS:0]   diff_x, diff_y;
    logic [SPAN_BITS-1:0]         ld_span_x, ld_span_y;
    logic signed [ERR_BITS-1:0]   sx_ext, sy_ext, ld_sx_ext, ld_sy_ext;
    logic signed [ERR_BITS:0]     twice, neg_sy, pos_sx;
    logic                         move_x, move_y;
    logic                         done;

    always_comb
    begin
        is_start = (operation == blpg_pkg::OP_START);

        // Spans of a new line.
        diff_x    = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
        diff_y    = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
        ld_span_x = diff_x[COORD_BITS] ? SPAN_BITS'(-diff_x) : SPAN_BITS'(diff_x);
        ld_span_y = diff_y[COORD_BITS] ? SPAN_BITS'(-diff_y) : SPAN_BITS'(diff_y);
        ld_sx_ext = {2'b00, ld_span_x};
        ld_sy_ext = {2'b00, ld_span_y};

        // Doubled error compared against both spans of the running line.
        sx_ext = {2'b00, span_x_reg};
        sy_ext = {2'b00, span_y_reg};
        twice  = {err_reg, 1'b0};
        pos_sx = {3'b000, span_x_reg};
        neg_sy = -{3'b000, span_y_reg};
        move_x = (twice >= neg_sy);
        move_y = (twice <= pos_sx);

        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        goal_x_next = goal_x_reg;
        goal_y_next = goal_y_reg;
        span_x_next = span_x_reg;
        span_y_next = span_y_reg;
        dir_x_next  = dir_x_reg;
        dir_y_next  = dir_y_reg;
        err_next    = err_reg;

        if (is_start)
        begin
            cur_x_next  = start_x;
            cur_y_next  = start_y;
            goal_x_next = end_x;
            goal_y_next = end_y;
            span_x_next = ld_span_x;
            span_y_next = ld_span_y;
            dir_x_next  = !(start_x < end_x);
            dir_y_next  = !(start_y < end_y);
            err_next    = ld_sx_ext - ld_sy_ext;
        end
        else
        begin
            if (move_x)
            begin
                cur_x_next = dir_x_reg ? cur_x_reg - COORD_BITS'(1) : cur_x_reg + COORD_BITS'(1);
            end
            if (move_y)
            begin
                cur_y_next = dir_y_reg ? cur_y_reg - COORD_BITS'(1) : cur_y_reg + COORD_BITS'(1);
            end
            err_next = err_reg - (move_x ? sy_ext : '0) + (move_y ? sx_ext : '0);
        end

        done        = (cur_x_next == goal_x_next) && (cur_y_next == goal_y_next);
        active_next = !done;
        produce     = fire && (is_start || active_reg);
        pix_x       = cur_x_next;
        pix_y       = cur_y_next;
        pix_last    = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            span_x_reg <= '0;
            span_y_reg <= '0;
            dir_x_reg  <= 1'b0;
            dir_y_reg  <= 1'b0;
            err_reg    <= '0;
            active_reg <= 1'b0;
        end
        else if (produce)
        begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            goal_x_reg <= goal_x_next;
            goal_y_reg <= goal_y_next;
            span_x_reg <= span_x_next;
            span_y_reg <= span_y_next;
            dir_x_reg  <= dir_x_next;
            dir_y_reg  <= dir_y_next;
            err_reg    <= err_next;
            active_reg <= active_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/blpg_addr.sv -----
`default_nettype none

// Frame clipping and flipped-row framebuffer address for one pixel.
module blpg_addr #(
    parameter int COORD_BITS = 16
) (
    input  wire logic signed [COORD_BITS-1:0]        pix_x,
    input  wire logic signed [COORD_BITS-1:0]        pix_y,
    input  wire blpg_pkg::frame_t                    frame,
    output logic                                     in_frame,
    output logic [blpg_pkg::ADDR_BITS-1:0]           address
);

    localparam int CMP_BITS =
        ((COORD_BITS > blpg_pkg::FRAME_BITS) ? COORD_BITS : blpg_pkg::FRAME_BITS) + 1;
    localparam int PROD_BITS = 2 * blpg_pkg::FRAME_BITS;

    logic signed [CMP_BITS-1:0]         x_ext, y_ext, w_ext, h_ext, row_full;
    logic [blpg_pkg::FRAME_BITS-1:0]    row, col;
    logic [PROD_BITS-1:0]               prod, sum;

    always_comb
    begin
        x_ext = CMP_BITS'(pix_x);
        y_ext = CMP_BITS'(pix_y);
        w_ext = {{(CMP_BITS - blpg_pkg::FRAME_BITS){1'b0}}, frame.width};
        h_ext = {{(CMP_BITS - blpg_pkg::FRAME_BITS){1'b0}}, frame.height};

        in_frame = !x_ext[CMP_BITS-1] && (x_ext < w_ext)
                && !y_ext[CMP_BITS-1] && (y_ext < h_ext);

        // height - 1 - y, written as height plus the complement of y.
        row_full = h_ext + ~y_ext;
        row      = row_full[blpg_pkg::FRAME_BITS-1:0];
        col      = x_ext[blpg_pkg::FRAME_BITS-1:0];
        prod     = PROD_BITS'(row) * PROD_BITS'(frame.width);
        sum      = prod + PROD_BITS'(col);
        address  = in_frame ? sum[blpg_pkg::ADDR_BITS-1:0] : '0;
    end

endmodule

`default_nettype wire

// ----- rtl/bresenham_line_pixel_generator_top.sv -----
// Channel   Direction  Handshake           Payload
// config    in         cfg_we              cfg_index, cfg_data
// input     in         in_valid/in_stall   operation, start_x, start_y, end_x, end_y
// result    out        out_valid/out_stall pixel_x, pixel_y, in_frame, pixel_address, last
//
// One input transaction is accepted every cycle when the result side keeps up.
// A pixel passes through the input register and the two registers behind it: pixel (error-term
// update) and result (address).
// A step transaction with no line in progress is consumed and yields no result.
// rst_n clears all control state asynchronously; frame size returns to 700 by 700.
// A stalled result holds the pipeline only as far back as its first empty stage.
`default_nettype none

`include "bresenham_line_pixel_generator_top_defines.svh"

module bresenham_line_pixel_generator_top #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Configuration writes
    input  wire logic                                  cfg_we,
    input  wire logic [blpg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [blpg_pkg::FRAME_BITS-1:0]       cfg_data,
    // Input transactions
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  operation,
    input  wire logic signed [COORD_BITS-1:0]          start_x,
    input  wire logic signed [COORD_BITS-1:0]          start_y,
    input  wire logic signed [COORD_BITS-1:0]          end_x,
    input  wire logic signed [COORD_BITS-1:0]          end_y,
    // Result transactions
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [COORD_BITS-1:0]               pixel_x,
    output logic signed [COORD_BITS-1:0]               pixel_y,
    output logic                                       in_frame,
    output logic [blpg_pkg::ADDR_BITS-1:0]             pixel_address,
    output logic                                       last
);

    // Frame size registers.
    blpg_pkg::frame_t frame_reg, frame_next;

    // Input stage.
    logic                         s1_valid_reg, s1_valid_next;
    logic                         s1_op_reg;
    logic signed [COORD_BITS-1:0] s1_sx_reg, s1_sy_reg, s1_ex_reg, s1_ey_reg;

    // Pixel stage.
    logic                         s2_valid_reg, s2_valid_next;
    logic signed [COORD_BITS-1:0] s2_x_reg, s2_y_reg;
    logic                         s2_last_reg;

    // Result stage.
    logic                         out_valid_reg, out_valid_next;
    logic signed [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic                         out_in_frame_reg, out_last_reg;
    logic [blpg_pkg::ADDR_BITS-1:0] out_addr_reg;

    // Handshake between stages. Each stage may load when it is empty or when
    // its contents move on in the same cycle.
    logic out_ready, s2_ready, s1_ready;
    logic in_fire, s1_fire, s2_fire;

    logic                         produce;
    logic signed [COORD_BITS-1:0] pix_x, pix_y;
    logic                         pix_last;
    logic                         addr_in_frame;
    logic [blpg_pkg::ADDR_BITS-1:0] addr_value;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;
    assign in_fire   = in_valid && s1_ready;
    assign s1_fire   = s1_valid_reg && s2_ready;
    assign s2_fire   = s2_valid_reg && out_ready;

    // The user must send register writes only while the block is idle; it is not checked.
    always_comb
    begin
        frame_next = frame_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                blpg_pkg::REG_FRAME_WIDTH:  frame_next.width  = cfg_data;
                blpg_pkg::REG_FRAME_HEIGHT: frame_next.height = cfg_data;
                default:                    frame_next = frame_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg.width  <= blpg_pkg::FRAME_RESET;
            frame_reg.height <= blpg_pkg::FRAME_RESET;
        end
        else
        begin
            frame_reg <= frame_next;
        end
    end

    // Stage occupancy.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        // A step with no line in progress leaves a bubble here.
        s2_valid_next = s2_valid_reg;
        if (s1_fire)
        begin
            s2_valid_next = produce;
        end
        else if (s2_fire)
        begin
            s2_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s2_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers load only on a move into their stage.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg <= operation;
            s1_sx_reg <= start_x;
            s1_sy_reg <= start_y;
            s1_ex_reg <= end_x;
            s1_ey_reg <= end_y;
        end
        if (s1_fire)
        begin
            s2_x_reg    <= pix_x;
            s2_y_reg    <= pix_y;
            s2_last_reg <= pix_last;
        end
        if (s2_fire)
        begin
            out_x_reg        <= s2_x_reg;
            out_y_reg        <= s2_y_reg;
            out_in_frame_reg <= addr_in_frame;
            out_addr_reg     <= addr_value;
            out_last_reg     <= s2_last_reg;
        end
    end

    // The line state advances once for every item that leaves the input stage and yields a pixel.
    blpg_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (s1_fire),
        .operation (s1_op_reg),
        .start_x   (s1_sx_reg),
        .start_y   (s1_sy_reg),
        .end_x     (s1_ex_reg),
        .end_y     (s1_ey_reg),
        .produce   (produce),
        .pix_x     (pix_x),
        .pix_y     (pix_y),
        .pix_last  (pix_last)
    );

    // Clipping and the framebuffer address are worked out in the pixel stage.
    blpg_addr #(
        .COORD_BITS (COORD_BITS)
    ) u_addr (
        .pix_x    (s2_x_reg),
        .pix_y    (s2_y_reg),
        .frame    (frame_reg),
        .in_frame (addr_in_frame),
        .address  (addr_value)
    );

    assign out_valid     = out_valid_reg;
    assign pixel_x       = out_x_reg;
    assign pixel_y       = out_y_reg;
    assign in_frame      = out_in_frame_reg;
    assign pixel_address = out_addr_reg;
    assign last          = out_last_reg;

    // An empty input stage never pushes back.
    `BLPG_ASSERT_NOW(a_empty_never_stalls, !s1_valid_reg, !in_stall)
    // A pixel outside the frame carries a zero address.
    `BLPG_ASSERT_NOW(a_clip_zero_addr, out_valid_reg && !out_in_frame_reg, out_addr_reg == '0)
    // A pixel inside the frame has non-negative coordinates.
    `BLPG_ASSERT_NOW(a_in_frame_sign, out_valid_reg && out_in_frame_reg,
        !out_x_reg[COORD_BITS-1] && !out_y_reg[COORD_BITS-1])
    // A result moved on with nothing behind it leaves the output empty.
    `BLPG_ASSERT_NEXT(a_drain, out_valid_reg && !out_stall && !s2_valid_reg, !out_valid_reg)

endmodule

`default_nettype wire

// ----- sim/bresenham_line_pixel_generator_top_test.sv -----
module bresenham_line_pixel_generator_top_test;

    // The run is split into frame settings. After each one the generator is allowed
    // to drain before the frame registers are rewritten.
    localparam int COORD_W          = 16;
    localparam int PHASES           = 8;
    localparam int RANDOM_PER_PHASE = 219;
    localparam int SETTLE_CYCLES    = 8;
    localparam int DRAIN_LIMIT      = 4000;
    localparam int HOLD_CYCLES      = 150;
    localparam int PRINT_LIMIT      = 20;
    localparam int TIMEOUT_CYCLES   = 200000;

    // One input transaction as the sender holds it.
    typedef struct {
        blpg_pkg::op_t             op;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
    } line_item_t;

    // One pixel as the generator should report it.
    typedef struct {
        logic signed [COORD_W-1:0]      x;
        logic signed [COORD_W-1:0]      y;
        logic                           in_frame;
        logic [blpg_pkg::ADDR_BITS-1:0] addr;
        logic                           last;
    } pixel_t;

    logic                                clk;
    logic                                rst_n     = 1'b0;
    logic                                cfg_we    = 1'b0;
    logic [blpg_pkg::CFG_INDEX_BITS-1:0] cfg_index = blpg_pkg::REG_FRAME_WIDTH;
    logic [blpg_pkg::FRAME_BITS-1:0]     cfg_data  = '0;
    logic                                in_valid  = 1'b0;
    logic                                in_stall;
    logic                                operation = blpg_pkg::OP_START;
    logic signed [COORD_W-1:0]           start_x   = '0;
    logic signed [COORD_W-1:0]           start_y   = '0;
    logic signed [COORD_W-1:0]           end_x     = '0;
    logic signed [COORD_W-1:0]           end_y     = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic signed [COORD_W-1:0]           pixel_x;
    logic signed [COORD_W-1:0]           pixel_y;
    logic                                in_frame;
    logic [blpg_pkg::ADDR_BITS-1:0]      pixel_address;
    logic                                last;

    bresenham_line_pixel_generator_top #(
        .COORD_BITS (COORD_W)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .in_frame      (in_frame),
        .pixel_address (pixel_address),
        .last          (last)
    );

    // Transactions waiting to be offered, and pixels predicted but not yet seen.
    line_item_t item_queue[$];
    pixel_t     pixel_queue[$];
    line_item_t offered;

    // Our own copy of the frame registers and of the line in progress.
    logic [blpg_pkg::FRAME_BITS-1:0] frame_w = blpg_pkg::FRAME_RESET;
    logic [blpg_pkg::FRAME_BITS-1:0] frame_h = blpg_pkg::FRAME_RESET;
    longint                line_x  = 0;
    longint                line_y  = 0;
    longint                goal_x  = 0;
    longint                goal_y  = 0;
    longint                span_x  = 0;
    longint                span_y  = 0;
    longint                err_term = 0;
    bit                    back_x  = 1'b0;
    bit                    back_y  = 1'b0;
    bit                    drawing = 1'b0;

    int transactions_accepted = 0;
    int lines_started         = 0;
    int pixels_checked        = 0;
    int mismatch_count        = 0;
    int phase_no              = -1;
    int offer_gap             = 0;
    int stall_left            = 0;
    bit no_idle               = 1'b0;
    logic result_hold         = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Idle or stall length for one transaction; zero throughout the steady phases.
    function automatic int draw_wait();
        if (no_idle)
            return 0;
        return $urandom_range(0, 4);
    endfunction

    // Works out the pixel for the current position, using the frame size in force,
    // and queues it. The line stays in progress until the endpoint is produced.
    task automatic record_pixel();
        pixel_t p;
        longint w;
        longint h;
        longint spot;
        w = frame_w;
        h = frame_h;
        p.x = line_x[COORD_W-1:0];
        p.y = line_y[COORD_W-1:0];
        p.in_frame = (line_x >= 0) && (line_x < w) && (line_y >= 0) && (line_y < h);
        // The row is flipped so that y = 0 lands on the bottom row of the buffer.
        spot = p.in_frame ? (h - 1 - line_y) * w + line_x : 0;
        p.addr = spot[blpg_pkg::ADDR_BITS-1:0];
        p.last = (line_x == goal_x) && (line_y == goal_y);
        drawing = !p.last;
        pixel_queue.push_back(p);
    endtask

    // Advances our copy of the generator by one accepted transaction.
    task automatic predict_pixel(input line_item_t it);
        longint twice;
        if (it.op == blpg_pkg::OP_START)
        begin
            // A start always replaces whatever line was in progress.
            line_x = it.sx;
            line_y = it.sy;
            goal_x = it.ex;
            goal_y = it.ey;
            span_x = (goal_x >= line_x) ? goal_x - line_x : line_x - goal_x;
            span_y = (goal_y >= line_y) ? goal_y - line_y : line_y - goal_y;
            back_x = !(line_x < goal_x);
            back_y = !(line_y < goal_y);
            err_term = span_x - span_y;
            lines_started++;
            record_pixel();
        end
        else if (drawing)
        begin
            // Both comparisons use the doubled error from before this step.
            twice = 2 * err_term;
            if (twice >= -span_y)
            begin
                err_term -= span_y;
                line_x += (back_x ? -1 : 1);
            end
            if (twice <= span_x)
            begin
                err_term += span_x;
                line_y += (back_y ? -1 : 1);
            end
            record_pixel();
        end
    endtask

    task automatic check_pixel();
        pixel_t want;
        if (pixel_queue.size() == 0)
        begin
            report_mismatch($sformatf("pixel (%0d,%0d) arrived with none expected",
                                      pixel_x, pixel_y));
            return;
        end
        want = pixel_queue.pop_front();
        pixels_checked++;
        if (pixel_x !== want.x)
            report_mismatch($sformatf("pixel %0d: x %0d, expected %0d",
                                      pixels_checked, pixel_x, want.x));
        if (pixel_y !== want.y)
            report_mismatch($sformatf("pixel %0d: y %0d, expected %0d",
                                      pixels_checked, pixel_y, want.y));
        if (in_frame !== want.in_frame)
            report_mismatch($sformatf("pixel %0d: in_frame %b, expected %b",
                                      pixels_checked, in_frame, want.in_frame));
        if (pixel_address !== want.addr)
            report_mismatch($sformatf("pixel %0d: address %0d, expected %0d",
                                      pixels_checked, pixel_address, want.addr));
        if (last !== want.last)
            report_mismatch($sformatf("pixel %0d: last %b, expected %b",
                                      pixels_checked, last, want.last));
    endtask

    // A step transaction carries random coordinates, which the generator must ignore.
    function automatic line_item_t step_item();
        line_item_t it;
        it.op = blpg_pkg::OP_STEP;
        it.sx = COORD_W'($urandom);
        it.sy = COORD_W'($urandom);
        it.ex = COORD_W'($urandom);
        it.ey = COORD_W'($urandom);
        return it;
    endfunction

    function automatic longint rand_coord();
        logic signed [COORD_W-1:0] v;
        v = COORD_W'($urandom);
        return v;
    endfunction

    // Queues a start transaction followed by a number of step transactions.
    task automatic queue_line(input longint x0, input longint y0, input longint x1,
                              input longint y1, input int steps);
        line_item_t it;
        it.op = blpg_pkg::OP_START;
        it.sx = x0[COORD_W-1:0];
        it.sy = y0[COORD_W-1:0];
        it.ex = x1[COORD_W-1:0];
        it.ey = y1[COORD_W-1:0];
        item_queue.push_back(it);
        repeat (steps) item_queue.push_back(step_item());
    endtask

    // Mostly short lines near the frame, stepped to their end. Some are cut short by
    // the next start, some are followed by steps with nothing in progress, and a few
    // use endpoints anywhere in the coordinate space or are lone steps.
    task automatic queue_random_run(inout int counted);
        int     kind;
        int     reach;
        int     steps;
        int     need;
        longint x0;
        longint y0;
        longint x1;
        longint y1;
        longint ax;
        longint ay;
        kind = $urandom_range(0, 15);
        if (kind == 0)
        begin
            // Such lines are usually far too long to finish, so they are dropped.
            steps = $urandom_range(0, 5);
            queue_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(), steps);
            counted += 1 + steps;
        end
        else if (kind == 1)
        begin
            repeat ($urandom_range(1, 3)) item_queue.push_back(step_item());
        end
        else
        begin
            reach = (kind < 13) ? 12 : 60;
            x0 = longint'($urandom_range(0, frame_w + 16)) - 8;
            y0 = longint'($urandom_range(0, frame_h + 16)) - 8;
            x1 = x0 + longint'($urandom_range(0, 2 * reach)) - reach;
            y1 = y0 + longint'($urandom_range(0, 2 * reach)) - reach;
            ax = (x1 >= x0) ? x1 - x0 : x0 - x1;
            ay = (y1 >= y0) ? y1 - y0 : y0 - y1;
            need = (ax > ay) ? ax : ay;
            case ($urandom_range(0, 5))
                0:       steps = $urandom_range(0, need);
                1:       steps = need + $urandom_range(1, 3);
                default: steps = need;
            endcase
            queue_line(x0, y0, x1, y1, steps);
            counted += 1 + ((steps < need) ? steps : need);
        end
    endtask

    task automatic write_frame_reg(input logic [blpg_pkg::CFG_INDEX_BITS-1:0] index,
                                   input logic [blpg_pkg::FRAME_BITS-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        if (index == blpg_pkg::REG_FRAME_WIDTH)
            frame_w = value;
        else
            frame_h = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every transaction has been taken and every predicted pixel has come
    // back, then lets the pipeline settle so that trailing idle steps have left it.
    task automatic drain_results();
        int waited;
        waited = 0;
        while (item_queue.size() != 0 || in_valid)
            @(negedge clk);
        while (pixel_queue.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (pixel_queue.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected pixels never arrived",
                                      pixel_queue.size()));
            pixel_queue.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Sender: offers queued transactions, with a random pause after each accepted one.
    // A stalled transaction is held unchanged until the generator takes it.
    always @(posedge clk or negedge rst_n)
    begin : drive_lines
        logic keep_offer;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            offer_gap = 0;
        end
        else
        begin
            keep_offer = in_valid;
            if (in_valid && !in_stall)
            begin
                predict_pixel(offered);
                transactions_accepted++;
                offer_gap = draw_wait();
                keep_offer = 1'b0;
            end
            if (!keep_offer)
            begin
                if (offer_gap > 0)
                    offer_gap--;
                else if (item_queue.size() != 0)
                begin
                    offered = item_queue.pop_front();
                    operation <= offered.op;
                    start_x   <= offered.sx;
                    start_y   <= offered.sy;
                    end_x     <= offered.ex;
                    end_y     <= offered.ey;
                    keep_offer = 1'b1;
                end
            end
            in_valid <= keep_offer;
        end
    end

    // Receiver: checks each accepted pixel, then stalls for a random number of cycles.
    // The long hold-off overrides this while it lasts.
    always @(posedge clk or negedge rst_n)
    begin : watch_pixels
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_pixel();
                stall_left = draw_wait();
            end
            if (result_hold)
                out_stall <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Twice in the run the receiver holds off for a long stretch while the sender
    // keeps offering, so the pipeline fills and the generator stalls its input.
    initial
    begin : hold_results
        int base_count;
        for (int n = 0; n < 2; n++)
        begin
            wait (phase_no == 3 + 3 * n);
            base_count = transactions_accepted;
            wait (transactions_accepted >= base_count + 40);
            @(posedge clk);
            result_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            result_hold <= 1'b0;
        end
    end

    initial
    begin : run_phases
        logic [blpg_pkg::FRAME_BITS-1:0] set_w;
        logic [blpg_pkg::FRAME_BITS-1:0] set_h;
        int                              counted;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            // The first setting is the 700 by 700 frame left by reset.
            if (phase > 0)
            begin
                case (phase)
                    1: begin set_w = 13'd1;    set_h = 13'd1;    end
                    2: begin set_w = 13'd4096; set_h = 13'd4096; end
                    3: begin set_w = 13'd0;    set_h = 13'd29;   end
                    4: begin set_w = 13'd37;   set_h = 13'd0;    end
                    // The largest register values make the address wrap at 24 bits.
                    5: begin set_w = 13'h1FFF; set_h = 13'h1FFF; end
                    6: begin set_w = 13'd64;   set_h = 13'd48;   end
                    default:
                    begin
                        set_w = blpg_pkg::FRAME_BITS'($urandom_range(1, 4096));
                        set_h = blpg_pkg::FRAME_BITS'($urandom_range(1, 4096));
                    end
                endcase
                write_frame_reg(blpg_pkg::REG_FRAME_WIDTH, set_w);
                write_frame_reg(blpg_pkg::REG_FRAME_HEIGHT, set_h);
            end
            no_idle = (phase == 2) || (phase == 5);
            phase_no = phase;
            @(negedge clk);
            if (phase == 0)
            begin
                // A step with no line in progress gives nothing.
                item_queue.push_back(step_item());
                // Equal endpoints give a single pixel marked last.
                queue_line(5, 5, 5, 5, 0);
                // Extreme endpoints, each dropped part way by the next start.
                queue_line(-32768, -32768, 32767, 32767, 1);
                queue_line(32767, -32768, -32768, 32767, 1);
                // Horizontal along the bottom row, vertical down the last column.
                queue_line(0, 0, 3, 0, 3);
                queue_line(699, 699, 699, 695, 4);
                // Leaves the frame across the right and bottom edges.
                queue_line(698, 2, 702, -1, 4);
                // Diagonal towards negative x, with one spare step after the end.
                queue_line(10, 10, 7, 13, 4);
            end
            counted = 0;
            while (counted < RANDOM_PER_PHASE)
                queue_random_run(counted);
            drain_results();
        end
        $display("Covered %0d input transactions with %0d line starts and %0d checked pixels,",
                 transactions_accepted, lines_started, pixels_checked);
        $display("over %0d frame sizes including empty, single-pixel and wrapping frames.",
                 PHASES);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Catches a generator that stops answering.
    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * 4);
        $display("Run timed out with %0d pixels outstanding", pixel_queue.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/blpg_pkg.sv
rtl/blpg_step.sv
rtl/blpg_addr.sv
rtl/bresenham_line_pixel_generator_top.sv
sim/bresenham_line_pixel_generator_top_test.sv
